@@ sv/tdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tdq_pkg;

   localparam int ID_W     = 4;
   localparam int POS_W    = 16;
   localparam int TIME_W   = 32;
   localparam int SEQ_W    = 64;
   localparam int REASON_W = 3;
   localparam int SQ_W     = 31;
   localparam int DIST_W   = 32;
   localparam int LIM_W    = 30;
   localparam int RANGE_W  = 15;
   localparam int MS_W     = 16;
   localparam int MASK_W   = 16;

   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic CMD_ARMOR = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [REASON_W-1:0] REASON_NO_SOURCES = 3'd0;
   localparam logic [REASON_W-1:0] REASON_EPOCH      = 3'd1;
   localparam logic [REASON_W-1:0] REASON_STABLE     = 3'd2;
   localparam logic [REASON_W-1:0] REASON_UNSTABLE   = 3'd3;
   localparam logic [REASON_W-1:0] REASON_LOST_HOLD  = 3'd4;
   localparam logic [REASON_W-1:0] REASON_NONE       = 3'd5;

   localparam logic [REG_IDX_W-1:0] REG_ID_MASK     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LOST_HOLD   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FRESH_LIMIT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STABLE_MIN  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_GAP_ALLOW   = 3'd5;

   localparam logic [MASK_W-1:0]  RST_ID_MASK     = 16'd190;
   localparam logic [RANGE_W-1:0] RST_MAX_RANGE   = 15'd8000;
   localparam logic [MS_W-1:0]    RST_LOST_HOLD   = 16'd0;
   localparam logic [MS_W-1:0]    RST_FRESH_LIMIT = 16'd500;
   localparam logic [MS_W-1:0]    RST_STABLE_MIN  = 16'd0;
   localparam logic [MS_W-1:0]    RST_GAP_ALLOW   = 16'd0;

   typedef struct packed {
      logic [MASK_W-1:0]  id_mask;
      logic [RANGE_W-1:0] max_range_mm;
      logic [MS_W-1:0]    lost_hold_ms;
      logic [MS_W-1:0]    fresh_limit_ms;
      logic [MS_W-1:0]    stable_min_ms;
      logic [MS_W-1:0]    gap_allow_ms;
   } cfg_type;

   typedef struct packed {
      logic                    command;
      logic [ID_W-1:0]         target_id;
      logic                    target_id_present;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TIME_W-1:0]       now_ms;
      logic [SEQ_W-1:0]        frame_seq;
      logic [SEQ_W-1:0]        motion_epoch_in;
      logic                    sources_ready;
   } req_type;

   typedef struct packed {
      logic              command;
      logic              match;
      logic [TIME_W-1:0] now_ms;
      logic [SEQ_W-1:0]  frame_seq;
      logic [SEQ_W-1:0]  motion_epoch_in;
      logic              sources_ready;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage
`default_nettype wire

@@ sv/tdq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tdq_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tdq_pkg::cfg_type    cfg,
   input  wire logic                req_valid,
   input  wire tdq_pkg::req_type    req,
   output logic                     req_ready,
   input  wire tdq_pkg::qstat_type  qstat,
   output logic                     push,
   output tdq_pkg::entry_type       push_entry
);

   logic                         s1_valid_ff, s1_valid_in;
   logic                         cmd_ff;
   logic                         id_ok_ff;
   logic [tdq_pkg::SQ_W-1:0]     sq_x_ff, sq_y_ff, sq_z_ff;
   logic [tdq_pkg::TIME_W-1:0]   now_ff;
   logic [tdq_pkg::SEQ_W-1:0]    seq_ff, epoch_ff;
   logic                         src_ff;
   logic [tdq_pkg::LIM_W-1:0]    lim_ff, lim_in;

   logic                         accept;
   logic                         id_ok;
   logic signed [31:0]           sq_x, sq_y, sq_z;
   logic [tdq_pkg::DIST_W-1:0]   dist2;

   assign req_ready = !s1_valid_ff || !qstat.full;
   assign accept    = req_valid && req_ready;
   assign push      = s1_valid_ff && !qstat.full;

   assign id_ok = req.target_id_present && cfg.id_mask[req.target_id];
   assign sq_x  = tdq_pkg::DIST_W'(req.pos_x) * tdq_pkg::DIST_W'(req.pos_x);
   assign sq_y  = tdq_pkg::DIST_W'(req.pos_y) * tdq_pkg::DIST_W'(req.pos_y);
   assign sq_z  = tdq_pkg::DIST_W'(req.pos_z) * tdq_pkg::DIST_W'(req.pos_z);
   assign lim_in = tdq_pkg::LIM_W'(cfg.max_range_mm) * tdq_pkg::LIM_W'(cfg.max_range_mm);

   assign s1_valid_in = accept || (s1_valid_ff && qstat.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
      if (accept) begin
         cmd_ff   <= req.command;
         id_ok_ff <= id_ok;
         sq_x_ff  <= sq_x[tdq_pkg::SQ_W-1:0];
         sq_y_ff  <= sq_y[tdq_pkg::SQ_W-1:0];
         sq_z_ff  <= sq_z[tdq_pkg::SQ_W-1:0];
         now_ff   <= req.now_ms;
         seq_ff   <= req.frame_seq;
         epoch_ff <= req.motion_epoch_in;
         src_ff   <= req.sources_ready;
      end
   end

   assign dist2 = tdq_pkg::DIST_W'(sq_x_ff) + tdq_pkg::DIST_W'(sq_y_ff)
                + tdq_pkg::DIST_W'(sq_z_ff);

   always_comb begin
      push_entry.command         = cmd_ff;
      push_entry.match           = id_ok_ff && (dist2 <= tdq_pkg::DIST_W'(lim_ff));
      push_entry.now_ms          = now_ff;
      push_entry.frame_seq       = seq_ff;
      push_entry.motion_epoch_in = epoch_ff;
      push_entry.sources_ready   = src_ff;
   end

endmodule
`default_nettype wire

@@ sv/tdq_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tdq_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tdq_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output tdq_pkg::entry_type       head,
   output tdq_pkg::qstat_type       qstat
);

   localparam logic [tdq_pkg::QCNT_W-1:0] DEPTH_CNT = tdq_pkg::QCNT_W'(tdq_pkg::QUEUE_DEPTH);

   tdq_pkg::entry_type               mem_ff [tdq_pkg::QUEUE_DEPTH];
   logic [tdq_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [tdq_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head            = mem_ff[rd_ptr_ff];
   assign qstat.full      = (count_ff == DEPTH_CNT);
   assign qstat.not_empty = (count_ff != '0);

endmodule
`default_nettype wire

@@ sv/tdq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tdq_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tdq_pkg::cfg_type             cfg,
   input  wire tdq_pkg::entry_type           head,
   input  wire tdq_pkg::qstat_type           qstat,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_detected,
   output logic [tdq_pkg::REASON_W-1:0]      rsp_reason
);

   logic                            pending_ff, pending_in;
   logic                            epoch_known_ff, epoch_known_in;
   logic [tdq_pkg::SEQ_W-1:0]       last_epoch_ff, last_epoch_in;
   logic                            seq_known_ff, seq_known_in;
   logic [tdq_pkg::SEQ_W-1:0]       last_seq_ff, last_seq_in;
   logic [tdq_pkg::TIME_W-1:0]      last_frame_time_ff, last_frame_time_in;
   logic                            frame_had_hit_ff, frame_had_hit_in;
   logic                            ever_hit_ff, ever_hit_in;
   logic [tdq_pkg::TIME_W-1:0]      last_hit_time_ff, last_hit_time_in;
   logic                            cont_on_ff, cont_on_in;
   logic [tdq_pkg::TIME_W-1:0]      cont_start_ff, cont_start_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            det_ff, det_in;
   logic [tdq_pkg::REASON_W-1:0]    reason_ff, reason_in;

   logic [tdq_pkg::TIME_W-1:0]      now;
   logic [tdq_pkg::TIME_W-1:0]      age_frame, age_hit, age_start, start_eff;
   logic                            new_frame, cont_kept, start_new, gap_over;

   assign now       = head.now_ms;
   assign pop       = qstat.not_empty &&
                      (head.command == tdq_pkg::CMD_ARMOR || !rsp_valid_ff || rsp_ready);
   assign age_frame = now - last_frame_time_ff;
   assign age_hit   = now - last_hit_time_ff;
   assign new_frame = seq_known_ff ? (head.frame_seq != last_seq_ff) : (head.frame_seq != '0);
   assign cont_kept = cont_on_ff &&
                      !(age_frame > tdq_pkg::TIME_W'(cfg.fresh_limit_ms));
   assign start_new = new_frame && pending_ff && !cont_kept;
   assign start_eff = start_new ? now : cont_start_ff;
   assign age_start = now - start_eff;
   assign gap_over  = age_hit > tdq_pkg::TIME_W'(cfg.gap_allow_ms);

   always_comb begin
      logic co, fhh, eh, fresh, stable;
      co                 = cont_on_ff;
      fhh                = frame_had_hit_ff;
      eh                 = ever_hit_ff;
      fresh              = 1'b0;
      stable             = 1'b0;
      pending_in         = pending_ff;
      epoch_known_in     = epoch_known_ff;
      last_epoch_in      = last_epoch_ff;
      seq_known_in       = seq_known_ff;
      last_seq_in        = last_seq_ff;
      last_frame_time_in = last_frame_time_ff;
      frame_had_hit_in   = frame_had_hit_ff;
      ever_hit_in        = ever_hit_ff;
      last_hit_time_in   = last_hit_time_ff;
      cont_on_in         = cont_on_ff;
      cont_start_in      = cont_start_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      det_in             = det_ff;
      reason_in          = reason_ff;

      if (pop) begin
         if (head.command == tdq_pkg::CMD_ARMOR) begin
            if (head.match) begin
               pending_in = 1'b1;
            end
         end else begin
            pending_in   = 1'b0;
            rsp_valid_in = 1'b1;
            if (!head.sources_ready) begin
               det_in    = 1'b0;
               reason_in = tdq_pkg::REASON_NO_SOURCES;
            end else if (epoch_known_ff && head.motion_epoch_in != last_epoch_ff) begin
               last_epoch_in    = head.motion_epoch_in;
               last_seq_in      = head.frame_seq;
               seq_known_in     = 1'b1;
               ever_hit_in      = 1'b0;
               cont_on_in       = 1'b0;
               frame_had_hit_in = 1'b0;
               det_in           = 1'b0;
               reason_in        = tdq_pkg::REASON_EPOCH;
            end else begin
               epoch_known_in = 1'b1;
               last_epoch_in  = head.motion_epoch_in;
               seq_known_in   = 1'b1;
               // last_seq ends equal to frame_seq on every path here
               last_seq_in    = head.frame_seq;
               if (new_frame) begin
                  co                 = cont_kept;
                  last_frame_time_in = now;
                  fhh                = pending_ff;
                  if (pending_ff) begin
                     eh               = 1'b1;
                     last_hit_time_in = now;
                     if (!co) begin
                        co            = 1'b1;
                        cont_start_in = now;
                     end
                  end
                  if (!pending_ff &&
                      (!ever_hit_ff || cfg.gap_allow_ms == '0 || gap_over)) begin
                     co = 1'b0;
                  end
               end
               fresh = new_frame || (age_frame <= tdq_pkg::TIME_W'(cfg.fresh_limit_ms));
               if (fhh && fresh) begin
                  stable = (cfg.stable_min_ms == '0) ||
                           (age_start >= tdq_pkg::TIME_W'(cfg.stable_min_ms));
                  det_in    = stable;
                  reason_in = stable ? tdq_pkg::REASON_STABLE : tdq_pkg::REASON_UNSTABLE;
               end else begin
                  if (!fresh) begin
                     co = 1'b0;
                  end
                  if (co && eh && cfg.gap_allow_ms != '0 && gap_over) begin
                     co = 1'b0;
                  end
                  if (eh && cfg.lost_hold_ms != '0 &&
                      age_hit <= tdq_pkg::TIME_W'(cfg.lost_hold_ms)) begin
                     det_in    = 1'b1;
                     reason_in = tdq_pkg::REASON_LOST_HOLD;
                  end else begin
                     det_in    = 1'b0;
                     reason_in = tdq_pkg::REASON_NONE;
                  end
               end
               cont_on_in       = co;
               frame_had_hit_in = fhh;
               ever_hit_in      = eh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff         <= 1'b0;
         epoch_known_ff     <= 1'b0;
         last_epoch_ff      <= '0;
         seq_known_ff       <= 1'b0;
         last_seq_ff        <= '0;
         last_frame_time_ff <= '0;
         frame_had_hit_ff   <= 1'b0;
         ever_hit_ff        <= 1'b0;
         last_hit_time_ff   <= '0;
         cont_on_ff         <= 1'b0;
         cont_start_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         pending_ff         <= pending_in;
         epoch_known_ff     <= epoch_known_in;
         last_epoch_ff      <= last_epoch_in;
         seq_known_ff       <= seq_known_in;
         last_seq_ff        <= last_seq_in;
         last_frame_time_ff <= last_frame_time_in;
         frame_had_hit_ff   <= frame_had_hit_in;
         ever_hit_ff        <= ever_hit_in;
         last_hit_time_ff   <= last_hit_time_in;
         cont_on_ff         <= cont_on_in;
         cont_start_ff      <= cont_start_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      det_ff    <= det_in;
      reason_ff <= reason_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_detected = det_ff;
   assign rsp_reason   = reason_ff;

endmodule
`default_nettype wire

@@ sv/target_detection_qualifier_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Ports                                        Per transaction
// req       in   req_tvalid/req_tready, req_tdata, req_tuser  armor candidate or evaluate
// rsp       out  rsp_tvalid/rsp_tready, rsp_tdata             one verdict per evaluate
// csr       in   csr_psel/penable/pwrite/paddr/pwdata/...     register write or read
//
// One req transaction per cycle, sustained while rsp_tready is high; armor and evaluate mix freely.
// Front: the squares are registered, then the range sum and compare feed a 2-entry queue.
// Back: evaluates the queue head combinationally into the rsp output register.
// From req accept to rsp valid an item passes the front stage, a queue entry and the rsp output register.
// A stalled rsp holds the back at the next evaluate; the queue and the front stage
// then take up to two more items before req_tready drops.
// Synchronous active-high reset; no clearing pass.
module target_detection_qualifier_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [3:0] target_id, [4] target_id_present, [20:5] pos_x, [36:21] pos_y,
   // [52:37] pos_z, [84:53] now_ms, [148:85] frame_seq,
   // [212:149] motion_epoch_in, [213] sources_ready, [215:214] zero
   input  wire logic [tdq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] command
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] detected, [3:1] reason, [7:4] zero
   output logic [tdq_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tdq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tdq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tdq_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   tdq_pkg::cfg_type                 cfg_ff, cfg_in;
   tdq_pkg::req_type                 req;
   tdq_pkg::entry_type               push_entry, head;
   tdq_pkg::qstat_type               qstat;
   logic                             push, pop;
   logic                             csr_write;
   logic [tdq_pkg::REG_IDX_W-1:0]    reg_idx;
   logic                             det;
   logic [tdq_pkg::REASON_W-1:0]     reason;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[tdq_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            tdq_pkg::REG_ID_MASK:     cfg_in.id_mask        = csr_pwdata[tdq_pkg::MASK_W-1:0];
            tdq_pkg::REG_MAX_RANGE:   cfg_in.max_range_mm   = csr_pwdata[tdq_pkg::RANGE_W-1:0];
            tdq_pkg::REG_LOST_HOLD:   cfg_in.lost_hold_ms   = csr_pwdata[tdq_pkg::MS_W-1:0];
            tdq_pkg::REG_FRESH_LIMIT: cfg_in.fresh_limit_ms = csr_pwdata[tdq_pkg::MS_W-1:0];
            tdq_pkg::REG_STABLE_MIN:  cfg_in.stable_min_ms  = csr_pwdata[tdq_pkg::MS_W-1:0];
            tdq_pkg::REG_GAP_ALLOW:   cfg_in.gap_allow_ms   = csr_pwdata[tdq_pkg::MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.id_mask        <= tdq_pkg::RST_ID_MASK;
         cfg_ff.max_range_mm   <= tdq_pkg::RST_MAX_RANGE;
         cfg_ff.lost_hold_ms   <= tdq_pkg::RST_LOST_HOLD;
         cfg_ff.fresh_limit_ms <= tdq_pkg::RST_FRESH_LIMIT;
         cfg_ff.stable_min_ms  <= tdq_pkg::RST_STABLE_MIN;
         cfg_ff.gap_allow_ms   <= tdq_pkg::RST_GAP_ALLOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         tdq_pkg::REG_ID_MASK:     csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.id_mask);
         tdq_pkg::REG_MAX_RANGE:   csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.max_range_mm);
         tdq_pkg::REG_LOST_HOLD:   csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.lost_hold_ms);
         tdq_pkg::REG_FRESH_LIMIT: csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.fresh_limit_ms);
         tdq_pkg::REG_STABLE_MIN:  csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.stable_min_ms);
         tdq_pkg::REG_GAP_ALLOW:   csr_prdata = tdq_pkg::CSR_DATA_W'(cfg_ff.gap_allow_ms);
         default:                  csr_prdata = '0;
      endcase
   end

   always_comb begin
      req.command           = req_tuser;
      req.target_id         = req_tdata[3:0];
      req.target_id_present = req_tdata[4];
      req.pos_x             = req_tdata[20:5];
      req.pos_y             = req_tdata[36:21];
      req.pos_z             = req_tdata[52:37];
      req.now_ms            = req_tdata[84:53];
      req.frame_seq         = req_tdata[148:85];
      req.motion_epoch_in   = req_tdata[212:149];
      req.sources_ready     = req_tdata[213];
   end

   tdq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req        (req),
      .req_ready  (req_tready),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   tdq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   tdq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_detected (det),
      .rsp_reason   (reason)
   );

   assign rsp_tdata = {4'b0000, reason, det};

endmodule
`default_nettype wire

@@ sv/tdq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tdq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [tdq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   a_reason_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:1] <= tdq_pkg::REASON_NONE && rsp_tdata[7:4] == 4'b0000)
      else $error("illegal reason code or padding");

   a_detect_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ==
         (rsp_tdata[3:1] == tdq_pkg::REASON_STABLE ||
          rsp_tdata[3:1] == tdq_pkg::REASON_LOST_HOLD)))
      else $error("detected flag disagrees with reason");

endmodule

bind target_detection_qualifier_unit tdq_checker u_tdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
